### hw/rtl/bmhq_pkg.sv
// Shared types and constants for the min-heap queue.
// Holds the capacity, the count width, opcodes, status codes, the token struct
// and the one-hot state type. No dependencies.
package bmhq_pkg;

   localparam int CAPACITY = 1024;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int CNTO_W   = 11;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Token that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic                    valid;
      logic                    op;
      logic                    active;
      logic                    found;
      logic [CNT_W-1:0]        remain;
      logic signed [VAL_W-1:0] carry;
   } tok_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_RESP = 3'b100
   } state_type;

endpackage

### hw/rtl/bmhq_cell.sv
// One cell of the sorted row: holds one value and one token stage.
// Depends on bmhq_pkg for the token type and opcodes.
module bmhq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  bmhq_pkg::tok_type                up_tok,
   input  logic signed [bmhq_pkg::VAL_W-1:0] right_val,
   output logic signed [bmhq_pkg::VAL_W-1:0] cell_val,
   output bmhq_pkg::tok_type                cell_tok
);
   import bmhq_pkg::*;

   logic signed [VAL_W-1:0] val_ff, val_in;
   tok_type                 tok_ff, tok_in;
   logic                    last_occ;

   assign last_occ = (up_tok.remain == CNT_W'(1));

   always_comb begin
      val_in = val_ff;
      tok_in = up_tok;
      if (up_tok.valid && up_tok.active) begin
         tok_in.remain = CNT_W'(up_tok.remain - 1'b1);
         if (up_tok.op == OP_PUSH) begin
            if (up_tok.remain == '0) begin
               // first free slot: park the carried value
               val_in        = up_tok.carry;
               tok_in.active = 1'b0;
            end else if (up_tok.carry < val_ff) begin
               val_in       = up_tok.carry;
               tok_in.carry = val_ff;
            end
         end else begin
            if (up_tok.found || (val_ff == up_tok.carry)) begin
               tok_in.found = 1'b1;
               // close the gap; the last occupied cell just drops out
               if (last_occ) begin
                  tok_in.active = 1'b0;
               end else begin
                  val_in = right_val;
               end
            end else if (last_occ) begin
               tok_in.active = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.op     <= tok_in.op;
      tok_ff.active <= tok_in.active;
      tok_ff.found  <= tok_in.found;
      tok_ff.remain <= tok_in.remain;
      tok_ff.carry  <= tok_in.carry;
      val_ff        <= val_in;
   end

   assign cell_val = val_ff;
   assign cell_tok = tok_ff;

endmodule

### hw/rtl/binary_min_heap_queue.sv
// Min-priority queue of signed 32-bit values built as a sorted row of cells.
// A push or a delete is registered into the injection token, which then walks
// every cell, one per cycle; the response is built once it leaves the last cell.
// A push into a full queue or a delete from an empty one goes straight to the
// response without a token. One request at a time: a new one is held off until
// the response has been taken. Reset (synchronous) empties the queue.
module binary_min_heap_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic signed [bmhq_pkg::VAL_W-1:0]  req_operand_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic signed [bmhq_pkg::VAL_W-1:0]  rsp_minimum,
   output logic                              rsp_is_empty,
   output logic [bmhq_pkg::CNTO_W-1:0]        rsp_entry_count
);
   import bmhq_pkg::*;

   // The row keeps values in ascending order, cell 0 holding the minimum.
   // Which copy of a duplicate gets removed does not change the stored
   // multiset, so minimum, count and status match the heap exactly.

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   tok_type                 inj_ff, inj_in;
   logic [1:0]              status_ff, status_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic                    empty_ff, empty_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   logic signed [VAL_W-1:0] vals [CAPACITY];
   tok_type                 toks [CAPACITY];
   tok_type                 tail_tok;
   logic                    full;
   logic [CNT_W+CNTO_W-1:0] cnt_wide;

   // Cell row: each cell sees the token of its left neighbor and the value
   // of its right neighbor (the last cell sees its own value).
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      tok_type                 up_tok;
      logic signed [VAL_W-1:0] right_val;
      if (gi == 0) begin : g_head
         assign up_tok = inj_ff;
      end else begin : g_body
         assign up_tok = toks[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_val = vals[gi];
      end else begin : g_mid
         assign right_val = vals[gi+1];
      end
      bmhq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_tok    (up_tok),
         .right_val (right_val),
         .cell_val  (vals[gi]),
         .cell_tok  (toks[gi])
      );
   end

   assign tail_tok = toks[CAPACITY-1];
   assign full     = (fill_ff == CNT_W'(CAPACITY));

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      inj_in    = '0;
      status_in = status_ff;
      min_in    = min_ff;
      empty_in  = empty_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_opcode == OP_PUSH) && full) begin
                  // reject: nothing changes
                  status_in = STATUS_FULL;
                  min_in    = vals[0];
                  empty_in  = 1'b0;
                  cnt_in    = fill_ff;
                  state_in  = ST_RESP;
               end else if ((req_opcode == OP_DELETE) && (fill_ff == '0)) begin
                  status_in = STATUS_NOT_FOUND;
                  min_in    = '0;
                  empty_in  = 1'b1;
                  cnt_in    = fill_ff;
                  state_in  = ST_RESP;
               end else begin
                  // launch a token into cell 0
                  inj_in.valid  = 1'b1;
                  inj_in.op     = req_opcode;
                  inj_in.active = 1'b1;
                  inj_in.found  = 1'b0;
                  inj_in.remain = fill_ff;
                  inj_in.carry  = req_operand_value;
                  state_in      = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (tail_tok.valid) begin
               // token left the row: commit the count and build the response
               if (tail_tok.op == OP_PUSH) begin
                  fill_in   = CNT_W'(fill_ff + 1'b1);
                  status_in = STATUS_DONE;
               end else if (tail_tok.found) begin
                  fill_in   = CNT_W'(fill_ff - 1'b1);
                  status_in = STATUS_DONE;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
               empty_in = (fill_in == '0);
               min_in   = (fill_in == '0) ? '0 : vals[0];
               cnt_in   = fill_in;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         inj_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         inj_ff.valid <= inj_in.valid;
      end
      inj_ff.op     <= inj_in.op;
      inj_ff.active <= inj_in.active;
      inj_ff.found  <= inj_in.found;
      inj_ff.remain <= inj_in.remain;
      inj_ff.carry  <= inj_in.carry;
      status_ff     <= status_in;
      min_ff        <= min_in;
      empty_ff      <= empty_in;
      cnt_ff        <= cnt_in;
   end

   // Hold new requests off until the response has been taken.
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_status   = status_ff;
   assign rsp_minimum  = min_ff;
   assign rsp_is_empty = empty_ff;
   // Count port is 11 bits wide; wrap above 2047.
   assign cnt_wide        = {{CNTO_W{1'b0}}, cnt_ff};
   assign rsp_entry_count = cnt_wide[CNTO_W-1:0];

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register lost its one-hot code");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> (state_ff == ST_RUN))
      else $error("token left the row outside a running request");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && tail_tok.valid) |=>
         (fill_ff == $past(fill_ff)) ||
         (fill_ff == CNT_W'($past(fill_ff) + 1'b1)) ||
         (fill_ff == CNT_W'($past(fill_ff) - 1'b1)))
      else $error("fill count moved by more than one");

   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (fill_ff == '0)))
      else $error("empty flag disagrees with fill count");

endmodule
